// ===== rtl/wca_pkg.sv =====
`default_nettype none
package wca_pkg;

  localparam int unsigned SigmaW = 21;
  localparam logic [SigmaW-1:0] SigmaReset = 21'd65536;
  localparam logic [16:0] CutoffQ16 = 17'd82570;
  localparam int unsigned Frac = 22;
  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic signed [31:0] probe_x;
    logic signed [31:0] probe_y;
    logic signed [31:0] probe_z;
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic signed [31:0] nbr_z;
    logic               last_nbr;
  } in_item_t;

  typedef struct packed {
    logic [31:0] energy;
    logic        saturated;
  } out_item_t;

  // Work item handed from the front to the back: classified pair
  typedef struct packed {
    logic        active;   // pair lies inside the cutoff and needs the energy path
    logic        clamp;    // very close pair, term clamps
    logic [47:0] r2;       // squared distance, Q32.32 low bits (dx < 2^22)
    logic [41:0] sig2;     // sigma squared
    logic        last_nbr;
  } work_t;

endpackage
`default_nettype wire

// ===== rtl/wca_front.sv =====
`default_nettype none
module wca_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [wca_pkg::SigmaW-1:0] sigma,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire wca_pkg::in_item_t      in_item,
  output logic                        wk_valid,
  input  wire logic                   wk_ready,
  output wca_pkg::work_t              wk
);
  import wca_pkg::*;

  // Stage 1: axis distances
  logic        s1_valid;
  logic [22:0] s1_dx, s1_dy, s1_dz;
  logic        s1_far, s1_same, s1_last;
  // Stage 2: squares
  logic        s2_valid;
  logic [43:0] s2_x2, s2_y2, s2_z2;
  logic [41:0] s2_sig2;
  logic        s2_zero, s2_last;
  // Stage 3: classify
  logic        s3_valid;
  work_t       s3_wk;

  logic advance;
  assign advance  = !s3_valid || wk_ready;
  assign in_ready = advance;
  assign wk_valid = s3_valid;
  assign wk       = s3_wk;

  function automatic logic [32:0] adiff(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    adiff = d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic [32:0] dx, dy, dz;
  assign dx = adiff(in_item.probe_x, in_item.nbr_x);
  assign dy = adiff(in_item.probe_y, in_item.nbr_y);
  assign dz = adiff(in_item.probe_z, in_item.nbr_z);

  logic [47:0] r2;
  logic [63:0] lhs;
  logic [58:0] rhs;
  logic [44:0] sig8;
  assign r2   = 48'(s2_x2) + 48'(s2_y2) + 48'(s2_z2);
  assign lhs  = {r2, 16'd0};
  assign rhs  = 59'(s2_sig2) * 59'(CutoffQ16);
  assign sig8 = 45'(r2 < 48'h2000_0000_0000 ? r2 : 48'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dx   <= dx[22:0];
      s1_dy   <= dy[22:0];
      s1_dz   <= dz[22:0];
      s1_far  <= (dx >= 33'd4194304) || (dy >= 33'd4194304) || (dz >= 33'd4194304);
      s1_same <= (dx == '0) && (dy == '0) && (dz == '0);
      s1_last <= in_item.last_nbr;

      s2_x2   <= 44'(s1_dx[21:0]) * 44'(s1_dx[21:0]);
      s2_y2   <= 44'(s1_dy[21:0]) * 44'(s1_dy[21:0]);
      s2_z2   <= 44'(s1_dz[21:0]) * 44'(s1_dz[21:0]);
      s2_sig2 <= 42'(sigma) * 42'(sigma);
      s2_zero <= s1_far || s1_same;
      s2_last <= s1_last;

      s3_wk.active   <= !s2_zero && (64'(lhs) <= 64'(rhs));
      s3_wk.clamp    <= 51'(s2_sig2) >= {r2, 3'd0};
      s3_wk.r2       <= r2;
      s3_wk.sig2     <= s2_sig2;
      s3_wk.last_nbr <= s2_last;
    end
  end

  logic unused;
  assign unused = ^sig8;

endmodule
`default_nettype wire

// ===== rtl/wca_queue.sv =====
`default_nettype none
module wca_queue #(
  parameter int unsigned Depth = wca_pkg::QueueDepthDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire wca_pkg::work_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output wca_pkg::work_t      rd_data
);
  import wca_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t             mem [Depth];
  logic [AW-1:0]     wp, rp;
  logic [AW:0]       count;
  logic              do_wr, do_rd;

  assign wr_ready = count != (AW+1)'(Depth);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  // Move pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wca_div.sv =====
`default_nettype none
module wca_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [47:0] den,
  output logic             busy,
  output logic             done,
  output logic [25:0]      quo
);
  // Restoring division, one quotient bit per cycle; quotient < 2^25 known
  logic [5:0]  cnt;
  logic [48:0] rem;
  logic [63:0] n;
  logic [47:0] d;
  logic [49:0] trial;

  assign trial = {rem, n[63]} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      n   <= num;
      d   <= den;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      n   <= {n[62:0], 1'b0};
      if (!trial[49]) begin
        rem <= trial[48:0];
        quo <= {quo[24:0], 1'b1};
      end else begin
        rem <= {rem[47:0], n[63]};
        quo <= {quo[24:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wca_back.sv =====
`default_nettype none
module wca_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wk_valid,
  output logic                wk_ready,
  input  wire wca_pkg::work_t wk,
  output logic                empty,
  input  wire logic           pop,
  output wca_pkg::out_item_t  result
);
  import wca_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StSq    = 3'd2;
  localparam logic [2:0] StCube  = 3'd3;
  localparam logic [2:0] StTerm  = 3'd4;
  localparam logic [2:0] StAdd   = 3'd5;
  localparam logic [2:0] StUsq   = 3'd6;
  localparam logic [2:0] StScale = 3'd7;

  localparam logic [32:0] OneQ22 = 33'd4194304;

  logic [2:0]  state;
  logic [32:0] term;     // bit 32 marks a clamped or saturated term
  logic        last;
  logic [31:0] energy_sum;
  logic        sat_seen;
  logic        out_full;
  logic [25:0] s;
  logic [47:0] prod;
  logic [31:0] u;
  logic [63:0] sq;

  logic        div_start, div_busy, div_done;
  logic [25:0] quo;

  wca_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({wk.sig2[41:0], 22'd0}), .den(wk.r2),
    .busy(div_busy), .done(div_done), .quo(quo)
  );

  // Take a work item only with room for a possible result
  logic take;
  assign take      = (state == StIdle) && wk_valid && !out_full;
  assign wk_ready  = take;
  assign div_start = take && wk.active && !wk.clamp;
  assign empty     = !out_full;

  // s^2 in StSq, then s^2 * s; s < 2^25 and s^2 >> 22 < 2^28
  logic [52:0] mul;
  logic [32:0] t2;
  assign t2 = {prod[31:0], 1'b0};
  assign mul = (state == StSq) ? 53'(s) * 53'(s) : 53'(prod[27:0]) * 53'(s);

  logic [32:0] sum;
  assign sum = 33'(energy_sum) + 33'(term[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      energy_sum <= '0;
      sat_seen   <= 1'b0;
      out_full   <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      case (state)
        StIdle: if (take) begin
          last <= wk.last_nbr;
          if (!wk.active) begin
            term <= '0;
            state <= StAdd;
          end else if (wk.clamp) begin
            term <= {1'b1, 32'hFFFF_FFFF};
            state <= StAdd;
          end else begin
            state <= StDiv;
          end
        end
        StDiv: if (div_done) begin
          s <= quo;
          state <= StSq;
        end
        StSq: begin
          prod  <= 48'(mul >> Frac);
          state <= StCube;
        end
        StCube: begin
          prod  <= 48'(mul >> Frac);
          state <= StTerm;
        end
        StTerm: begin
          // u = |2t - 1.0|
          u <= (t2 >= OneQ22) ? 32'(t2 - OneQ22) : 32'(OneQ22 - t2);
          state <= StUsq;
        end
        StUsq: begin
          sq <= 64'(u) * 64'(u);
          state <= StScale;
        end
        StScale: begin
          // scale to Q16.16, clamp when it needs more than 32 bits
          term <= (sq[63:60] != 4'd0) ? {1'b1, 32'hFFFF_FFFF} : {1'b0, sq[59:28]};
          state <= StAdd;
        end
        StAdd: begin
          if (last) begin
            result.energy    <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            result.saturated <= sat_seen || term[32] || sum[32];
            out_full   <= 1'b1;
            energy_sum <= '0;
            sat_seen   <= 1'b0;
          end else begin
            energy_sum <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            sat_seen   <= sat_seen || term[32] || sum[32];
          end
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  logic unused;
  assign unused = div_busy ^ (^prod[47:32]) ^ (^sq[27:0]);

endmodule
`default_nettype wire

// ===== rtl/wca_pair_energy_accumulator_top.sv =====
`default_nettype none
// WCA pair energy accumulator.
// Input channel: push/full with one in_item per transfer (probe and
// neighbour point, last_nbr flag). Result channel: empty/pop; the oldest
// result is on result while empty is low and leaves on pop.
// sigma is written with sigma_we/sigma_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A front pipeline forms distances, r^2, sigma^2 and the cutoff class; a
// small queue feeds the back end, which takes one pair at a time: a pair
// outside the cutoff or clamped goes to the add step; a pair on the
// energy path runs the 64-step serial divider for s = sigma^2/r^2, then
// the square, cube, term, u^2 and scale steps. A result appears on the
// item marked last. If the receiver does not pop, the back end holds
// before the next pair; the queue then fills and full rises. Reset (rst,
// synchronous) clears sum, flag, queues; sigma returns to 1.0.
module wca_pair_energy_accumulator_top #(
  parameter int unsigned QueueDepth = wca_pkg::QueueDepthDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        sigma_we,
  input  wire logic [wca_pkg::SigmaW-1:0]  sigma_wdata,
  input  wire logic                        push,
  output logic                             full,
  input  wire wca_pkg::in_item_t           in_item,
  output logic                             empty,
  input  wire logic                        pop,
  output wca_pkg::out_item_t               result
);
  import wca_pkg::*;

  logic [SigmaW-1:0] sigma;
  always_ff @(posedge clk) begin
    if (rst) sigma <= SigmaReset;
    else if (sigma_we) sigma <= sigma_wdata;
  end

  logic  f_valid, f_ready, q_valid, q_ready, in_ready;
  work_t f_wk, q_wk;
  assign full = !in_ready;

  wca_front u_front (
    .clk(clk), .rst(rst), .sigma(sigma),
    .in_valid(push), .in_ready(in_ready), .in_item(in_item),
    .wk_valid(f_valid), .wk_ready(f_ready), .wk(f_wk)
  );

  wca_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_wk),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_wk)
  );

  wca_back u_back (
    .clk(clk), .rst(rst),
    .wk_valid(q_valid), .wk_ready(q_ready), .wk(q_wk),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule
`default_nettype wire
